/* rtl/icv_pkg.sv */
// Shared types and constants for the image kernel convolution block.
// No dependencies; imported by icv_resq and image_kernel_convolution_top.
package icv_pkg;

    typedef enum logic
    {
        OP_PIXEL = 1'b0,
        OP_COEF  = 1'b1
    } op_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;

    localparam int WIDTH_RESET  = 640;
    localparam int KERNEL_RESET = 3;

    localparam int KS_W      = 4;
    localparam int FRAC_BITS = 14;
    localparam int ROW_BITS  = 10;
    localparam int ROW_LIMIT = 1023;
    localparam int PIX_MAX   = 255;

    localparam int RQ_DEPTH = 8;
    localparam int RQ_AW    = 3;
    localparam int RQ_CW    = 4;

    typedef struct packed
    {
        logic [7:0] value;
        logic       valid_res;
        logic       last;
    } res_t;

endpackage

/* rtl/icv_linebuf.sv */
// Line buffer memory: one word per column holding the previous rows.
// Synchronous (registered) read, with same-edge write forwarding.
// Depends on nothing.
module icv_linebuf #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 48
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] line_mem [DEPTH];
    logic [DW-1:0] rd_data_reg;
    logic [DW-1:0] fwd_data_reg;
    logic          fwd_hit_reg;
    logic          fwd_hit_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= line_mem[rd_addr];
        end
        fwd_data_reg <= wr_data;
    end

    assign fwd_hit_next = rd_en && wr_en && (rd_addr == wr_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

endmodule

/* rtl/icv_resq.sv */
// Result queue between the arithmetic pipeline and the output channel.
// Depends on icv_pkg (res_t, queue depth constants).
module icv_resq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  icv_pkg::res_t push_data,
    output logic          res_valid,
    input  logic          res_ready,
    output icv_pkg::res_t head
);
    import icv_pkg::*;

    res_t             q_mem [RQ_DEPTH];
    logic [RQ_AW-1:0] wptr_reg;
    logic [RQ_AW-1:0] rptr_reg;
    logic [RQ_CW-1:0] count_reg;
    logic [RQ_CW-1:0] count_next;
    logic             pop;

    assign res_valid = (count_reg != '0);
    assign pop       = res_valid && res_ready;
    assign head      = q_mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/image_kernel_convolution_top.sv */
// Streaming 2D convolution of a raster grayscale image with a square kernel.
// Depends on icv_pkg, icv_linebuf and icv_resq.
//
// Usage:
//   item channel (item_valid/item_ready): op selects a pixel beat or a
//   coefficient write beat. Pixel beats arrive in raster order; end_of_frame
//   on the last pixel restarts row and column counting. Coefficient beats
//   load entry coef_index (row * MAX_KERNEL + column) and give no result.
//   res channel (res_valid/res_ready): one beat per pixel beat, in order,
//   for the window centre kernel_size/2 rows and columns back. valid_res is
//   low, with value zero, while the window overlaps the image border.
//   cfg port: cfg_we writes image_width, kernel_size or output_mode;
//   write only while no beat is in flight.
// Throughput: one item per clock while item_ready is high. The line buffer is
//   a single memory word per column, read at accept, written back the next cycle.
// Pipeline: a pixel beat passes line buffer read, window shift, multiply,
//   row sums, total, then round and clamp into the result queue.
// Stall: an 8-entry result queue absorbs the pipeline; item_ready drops
//   when 8 results are accepted but not yet delivered.
// Reset: counters, coefficients (zero) and config defaults clear at once;
//   no clearing pass is needed.
module image_kernel_convolution_top #(
    parameter int MAX_KERNEL = 7,
    parameter int MAX_WIDTH  = 1024,
    parameter int COEF_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [icv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [icv_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic                                op,
    input  logic [7:0]                          pixel,
    input  logic                                end_of_frame,
    input  logic [5:0]                          coef_index,
    input  logic signed [15:0]                  coef_value,
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic [7:0]                          value,
    output logic                                valid_res,
    output logic                                last
);
    import icv_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int CW     = (COL_W + 1 > CFG_DATA_W) ? COL_W + 1 : CFG_DATA_W;
    localparam int NL     = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
    localparam int LB_W   = NL * 8;
    localparam int PROD_W = COEF_BITS + 9;
    localparam int RS_W   = PROD_W + $clog2(MAX_KERNEL);
    localparam int SUM_W  = RS_W + $clog2(MAX_KERNEL);

    // configuration
    logic [CFG_DATA_W-1:0] image_width_reg;
    logic [2:0]            kernel_size_reg;
    logic                  output_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= CFG_DATA_W'(WIDTH_RESET);
            kernel_size_reg <= 3'(KERNEL_RESET);
            output_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  image_width_reg <= cfg_data;
                CFG_KERNEL: kernel_size_reg <= cfg_data[2:0];
                CFG_MODE:   output_mode_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    logic [CW-1:0]   w_raw;
    logic [CW-1:0]   w_eff;
    logic [KS_W-1:0] ks_eff;
    logic [KS_W-1:0] ks_m1;

    always_comb
    begin
        w_raw = CW'(image_width_reg);
        w_eff = w_raw;
        if (w_raw == '0)
        begin
            w_eff = CW'(1);
        end
        else if (w_raw > CW'(MAX_WIDTH))
        begin
            w_eff = CW'(MAX_WIDTH);
        end

        ks_eff = KS_W'(kernel_size_reg);
        if (ks_eff > KS_W'(MAX_KERNEL))
        begin
            ks_eff = KS_W'(MAX_KERNEL);
        end
        if (ks_eff == '0)
        begin
            ks_eff = KS_W'(1);
        end
        if (!ks_eff[0])
        begin
            ks_eff = ks_eff - 1'b1;
        end
        ks_m1 = ks_eff - 1'b1;
    end

    // input handshake and result credit
    logic             accept;
    logic             acc_pix;
    logic             acc_coef;
    logic             res_pop;
    logic [RQ_CW-1:0] pend_reg;
    logic [RQ_CW-1:0] pend_next;

    assign item_ready = (pend_reg < RQ_CW'(RQ_DEPTH));
    assign accept     = item_valid && item_ready;
    assign acc_pix    = accept && (op == OP_PIXEL);
    assign acc_coef   = accept && (op == OP_COEF);
    assign res_pop    = res_valid && res_ready;

    always_comb
    begin
        pend_next = pend_reg;
        unique case ({acc_pix, res_pop})
            2'b10:   pend_next = pend_reg + 1'b1;
            2'b01:   pend_next = pend_reg - 1'b1;
            default: pend_next = pend_reg;
        endcase
    end

    // position counters
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;
    logic [ROW_BITS-1:0] row_reg;
    logic [ROW_BITS-1:0] row_next;
    logic [CW-1:0]       col_inc;
    logic                win_inside;

    assign win_inside = (int'(row_reg) >= int'(ks_m1)) && (int'(col_reg) >= int'(ks_m1));

    always_comb
    begin
        col_inc  = CW'(col_reg) + 1'b1;
        col_next = col_reg;
        row_next = row_reg;
        if (acc_pix)
        begin
            priority if (end_of_frame)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_inc >= w_eff)
            begin
                col_next = '0;
                if (row_reg < ROW_BITS'(ROW_LIMIT))
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    // stage 1: line buffer read in flight
    logic                        s1_pix_reg;
    logic                        s1_coef_reg;
    logic [7:0]                  s1_pixel_reg;
    logic                        s1_eof_reg;
    logic                        s1_vr_reg;
    logic [COL_W-1:0]            s1_col_reg;
    logic [5:0]                  s1_cidx_reg;
    logic signed [COEF_BITS-1:0] s1_cval_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pixel;
            s1_eof_reg   <= end_of_frame;
            s1_vr_reg    <= win_inside;
            s1_col_reg   <= col_reg;
            s1_cidx_reg  <= coef_index;
            s1_cval_reg  <= COEF_BITS'(coef_value);
        end
    end

    logic [LB_W-1:0] lb_rd_data;
    logic [LB_W-1:0] lb_wr_data;
    logic [7:0]      v [NL+1];

    icv_linebuf #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W),
        .DW    (LB_W)
    ) u_linebuf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (acc_pix),
        .rd_addr (col_reg),
        .wr_en   (s1_pix_reg),
        .wr_addr (s1_col_reg),
        .wr_data (lb_wr_data),
        .rd_data (lb_rd_data)
    );

    assign v[0] = s1_pixel_reg;

    for (genvar j = 0; j < NL; j++)
    begin : g_lines
        assign v[j+1]               = lb_rd_data[j*8 +: 8];
        assign lb_wr_data[j*8 +: 8] = v[j];
    end

    // stage 2: window and coefficient table
    logic [7:0]                  win_reg  [MAX_KERNEL][MAX_KERNEL];
    logic signed [COEF_BITS-1:0] coef_reg [MAX_KERNEL][MAX_KERNEL];
    logic                        s2_res_reg;
    logic                        s2_vr_reg;
    logic                        s2_eof_reg;

    for (genvar k = 0; k < MAX_KERNEL; k++)
    begin : g_win_row
        always_ff @(posedge clk)
        begin
            if (s1_pix_reg)
            begin
                win_reg[k][0] <= v[k];
            end
        end
        for (genvar l = 1; l < MAX_KERNEL; l++)
        begin : g_win_col
            always_ff @(posedge clk)
            begin
                if (s1_pix_reg)
                begin
                    win_reg[k][l] <= win_reg[k][l-1];
                end
            end
        end
        for (genvar l = 0; l < MAX_KERNEL; l++)
        begin : g_coef
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    coef_reg[k][l] <= '0;
                end
                else if (s1_coef_reg && (int'(s1_cidx_reg) == k * MAX_KERNEL + l))
                begin
                    coef_reg[k][l] <= s1_cval_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s2_vr_reg  <= s1_vr_reg;
        s2_eof_reg <= s1_eof_reg;
    end

    // stage 3: products
    logic signed [PROD_W-1:0] prod_reg [MAX_KERNEL][MAX_KERNEL];
    logic                     s3_res_reg;
    logic                     s3_vr_reg;
    logic                     s3_eof_reg;

    for (genvar k = 0; k < MAX_KERNEL; k++)
    begin : g_mul_row
        for (genvar l = 0; l < MAX_KERNEL; l++)
        begin : g_mul
            always_ff @(posedge clk)
            begin
                if ((int'(ks_eff) > k) && (int'(ks_eff) > l))
                begin
                    prod_reg[k][l] <= PROD_W'(coef_reg[k][l]) *
                                      PROD_W'($signed({1'b0, win_reg[k][l]}));
                end
                else
                begin
                    prod_reg[k][l] <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s3_vr_reg  <= s2_vr_reg;
        s3_eof_reg <= s2_eof_reg;
    end

    // stage 4: row sums
    logic signed [RS_W-1:0] row_sum_next [MAX_KERNEL];
    logic signed [RS_W-1:0] row_sum_reg  [MAX_KERNEL];
    logic                   s4_res_reg;
    logic                   s4_vr_reg;
    logic                   s4_eof_reg;

    for (genvar k = 0; k < MAX_KERNEL; k++)
    begin : g_row_sum
        always_comb
        begin
            logic signed [RS_W-1:0] acc;
            acc = '0;
            for (int l = 0; l < MAX_KERNEL; l++)
            begin
                acc = acc + RS_W'(prod_reg[k][l]);
            end
            row_sum_next[k] = acc;
        end

        always_ff @(posedge clk)
        begin
            row_sum_reg[k] <= row_sum_next[k];
        end
    end

    always_ff @(posedge clk)
    begin
        s4_vr_reg  <= s3_vr_reg;
        s4_eof_reg <= s3_eof_reg;
    end

    // stage 5: total, then round and clamp into the queue
    logic signed [SUM_W-1:0] total_next;
    logic signed [SUM_W-1:0] total_reg;
    logic                    s5_res_reg;
    logic                    s5_vr_reg;
    logic                    s5_eof_reg;

    always_comb
    begin
        total_next = '0;
        for (int k = 0; k < MAX_KERNEL; k++)
        begin
            total_next = total_next + SUM_W'(row_sum_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg  <= total_next;
        s5_vr_reg  <= s4_vr_reg;
        s5_eof_reg <= s4_eof_reg;
    end

    logic signed [SUM_W:0]   base;
    logic signed [SUM_W+1:0] rounded;
    logic signed [SUM_W+1:0] shifted;
    logic [7:0]              clamped;
    res_t                    push_data;
    res_t                    head;

    always_comb
    begin
        base = (SUM_W+1)'(total_reg);
        if (output_mode_reg && (total_reg < 0))
        begin
            base = -(SUM_W+1)'(total_reg);
        end
        rounded = (SUM_W+2)'(base) + (SUM_W+2)'(2 ** (FRAC_BITS - 1));
        shifted = rounded >>> FRAC_BITS;
        priority if (rounded < 0)
        begin
            clamped = '0;
        end
        else if (shifted > (SUM_W+2)'(PIX_MAX))
        begin
            clamped = 8'(PIX_MAX);
        end
        else
        begin
            clamped = shifted[7:0];
        end

        push_data.value     = s5_vr_reg ? clamped : 8'd0;
        push_data.valid_res = s5_vr_reg;
        push_data.last      = s5_eof_reg;
    end

    icv_resq u_resq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s5_res_reg),
        .push_data (push_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .head      (head)
    );

    assign value     = head.value;
    assign valid_res = head.valid_res;
    assign last      = head.last;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            s1_pix_reg  <= 1'b0;
            s1_coef_reg <= 1'b0;
            s2_res_reg  <= 1'b0;
            s3_res_reg  <= 1'b0;
            s4_res_reg  <= 1'b0;
            s5_res_reg  <= 1'b0;
        end
        else
        begin
            pend_reg    <= pend_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            s1_pix_reg  <= acc_pix;
            s1_coef_reg <= acc_coef;
            s2_res_reg  <= s1_pix_reg;
            s3_res_reg  <= s2_res_reg;
            s4_res_reg  <= s3_res_reg;
            s5_res_reg  <= s4_res_reg;
        end
    end

endmodule

/* sim/tb.sv */
// Self-checking testbench for image_kernel_convolution_top: border and clamp cases,
// odd register settings, row wrap on a width change, then random frames.
// Depends on icv_pkg and the RTL of the block; results are predicted in-line and compared.
module tb;
    import icv_pkg::*;

    localparam int KMAX  = 7;
    localparam int WMAX  = 1024;
    localparam int NCOEF = KMAX * KMAX;
    localparam longint HALF = longint'(1) << (FRAC_BITS - 1);

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  item_valid;
    logic                  item_ready;
    logic                  op;
    logic [7:0]            pixel;
    logic                  end_of_frame;
    logic [5:0]            coef_index;
    logic signed [15:0]    coef_value;
    logic                  res_valid;
    logic                  res_ready;
    logic [7:0]            value;
    logic                  valid_res;
    logic                  last;

    // prediction state
    logic [7:0]         line_mem [KMAX-1][WMAX];
    logic [7:0]         win [KMAX][KMAX];
    logic signed [15:0] coef_tab [NCOEF];
    int unsigned        row_cnt;
    int unsigned        col_cnt;
    int unsigned        width_reg;
    int unsigned        kernel_reg;
    int unsigned        mode_reg;
    res_t               conv_results [$];

    int bad_pixels;
    int beats_sent;
    int tx_run;
    int rx_run;

    image_kernel_convolution_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .op           (op),
        .pixel        (pixel),
        .end_of_frame (end_of_frame),
        .coef_index   (coef_index),
        .coef_value   (coef_value),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .value        (value),
        .valid_res    (valid_res),
        .last         (last)
    );

    always #2 clk = ~clk;

    function automatic int draw_gap(inout int run_left);
        if (run_left > 0)
        begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            run_left = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: rand_pixel = 8'd0;
            1: rand_pixel = 8'd255;
            default: rand_pixel = 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 9))
            0: rand_coef = 16'h8000;
            1: rand_coef = 16'h7fff;
            2, 3: rand_coef = 16'($urandom);
            default: rand_coef = 16'($urandom_range(0, 8191) - 4096);
        endcase
    endfunction

    task automatic convolve_beat(input logic o, input logic [7:0] px, input logic eof,
                                 input logic [5:0] ci, input logic [15:0] cv);
        logic [7:0]  taps [KMAX];
        int unsigned w;
        int unsigned ks;
        int unsigned hk;
        int unsigned c;
        int unsigned r;
        longint      acc;
        longint      q;
        res_t        want;
        if (o == OP_COEF)
        begin
            if (ci < NCOEF)
                coef_tab[ci] = cv;
        end
        else
        begin
            c  = col_cnt;
            r  = row_cnt;
            w  = (width_reg == 0) ? 1 : ((width_reg > WMAX) ? WMAX : width_reg);
            ks = (kernel_reg > KMAX) ? KMAX : kernel_reg;
            if (ks == 0)
                ks = 1;
            if (ks % 2 == 0)
                ks = ks - 1;
            hk = ks / 2;

            taps[0] = px;
            for (int k = 1; k < KMAX; k++)
                taps[k] = line_mem[k-1][c];
            for (int k = 0; k < KMAX - 1; k++)
                line_mem[k][c] = taps[k];
            for (int k = 0; k < KMAX; k++)
            begin
                for (int l = KMAX - 1; l > 0; l--)
                    win[k][l] = win[k][l-1];
                win[k][0] = taps[k];
            end

            want      = '0;
            want.last = eof;
            if (r >= 2 * hk && c >= 2 * hk)
            begin
                acc = 0;
                for (int k = 0; k < ks; k++)
                    for (int l = 0; l < ks; l++)
                        acc += longint'(coef_tab[k*KMAX+l]) * longint'(win[k][l]);
                if (mode_reg != 0)
                begin
                    if (acc < 0)
                        acc = -acc;
                    q = (acc + HALF) >>> FRAC_BITS;
                end
                else
                    q = (acc + HALF < 0) ? 0 : ((acc + HALF) >>> FRAC_BITS);
                want.value     = (q > PIX_MAX) ? 8'(PIX_MAX) : 8'(q);
                want.valid_res = 1'b1;
            end

            if (eof)
            begin
                row_cnt = 0;
                col_cnt = 0;
            end
            else if (c + 1 >= w)
            begin
                col_cnt = 0;
                if (row_cnt < ROW_LIMIT)
                    row_cnt++;
            end
            else
                col_cnt = c + 1;
            conv_results.push_back(want);
        end
    endtask

    task automatic push_beat(input logic o, input logic [7:0] px, input logic eof,
                             input logic [5:0] ci, input logic [15:0] cv);
        int gap;
        gap = draw_gap(tx_run);
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid   <= 1'b1;
        op           <= o;
        pixel        <= px;
        end_of_frame <= eof;
        coef_index   <= ci;
        coef_value   <= cv;
        do @(posedge clk); while (!item_ready);
        convolve_beat(o, px, eof, ci, cv);
        beats_sent++;
    endtask

    task automatic send_pixel(input logic [7:0] px, input logic eof);
        push_beat(OP_PIXEL, px, eof, 6'($urandom), 16'($urandom));
    endtask

    task automatic send_coef(input logic [5:0] idx, input logic [15:0] cv);
        push_beat(OP_COEF, 8'($urandom), 1'($urandom), idx, cv);
    endtask

    // drop valid and wait until the pipeline is empty
    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (conv_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_WIDTH:  width_reg  = data;
            CFG_KERNEL: kernel_reg = data[2:0];
            CFG_MODE:   mode_reg   = data[0];
            default: ;
        endcase
    endtask

    // upper bits of kernel and mode data are don't-care
    task automatic configure(input int unsigned w, input int unsigned ks, input int unsigned m);
        write_reg(CFG_WIDTH, 11'(w));
        write_reg(CFG_KERNEL, {8'($urandom), 3'(ks)});
        write_reg(CFG_MODE, {10'($urandom), 1'(m)});
    endtask

    task automatic note_mismatch(input string field, input logic [7:0] want, input logic [7:0] got);
        bad_pixels++;
        if (bad_pixels <= 10)
            $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    endtask

    task automatic check_filtered();
        res_t want;
        if (conv_results.size() == 0)
        begin
            bad_pixels++;
            if (bad_pixels <= 10)
                $display("unexpected result beat: value %0d valid_res %b last %b",
                         value, valid_res, last);
        end
        else
        begin
            want = conv_results.pop_front();
            if (value !== want.value)
                note_mismatch("value", want.value, value);
            if (valid_res !== want.valid_res)
                note_mismatch("valid_res", 8'(want.valid_res), 8'(valid_res));
            if (last !== want.last)
                note_mismatch("last", 8'(want.last), 8'(last));
        end
    endtask

    task automatic test_coef_extremes();
        settle();
        configure(3, 3, 0);
        send_coef(6'd0, 16'h7fff);
        send_coef(6'd8, 16'h8000);
        send_coef(6'd16, 16'h4000);
        send_coef(6'd48, 16'h7fff);
        send_coef(6'd49, 16'h1234);
        send_coef(6'd63, 16'hffff);
        for (int i = 0; i < 9; i++)
            send_pixel((i % 3 == 1) ? 8'd0 : 8'd255, i == 8);
        settle();
        write_reg(CFG_MODE, 11'd1);
        for (int i = 0; i < 9; i++)
            send_pixel((i % 2 == 0) ? 8'd0 : 8'd255, i == 8);
    endtask

    task automatic test_odd_settings();
        settle();
        configure(0, 0, 0);
        send_coef(6'd0, 16'h4000);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd1, 1'b1);
        settle();
        configure(2047, 2, 1);
        send_coef(6'd0, 16'hc000);
        for (int i = 0; i < 6; i++)
            send_pixel(rand_pixel(), i == 5);
        settle();
        configure(6, 6, 0);
        send_coef(6'd0, 16'h2000);
        send_coef(6'd16, 16'h2000);
        send_coef(6'd32, 16'h2000);
        for (int i = 0; i < 36; i++)
            send_pixel(rand_pixel(), i == 35);
    endtask

    task automatic test_width_shrink();
        settle();
        configure(8, 3, 0);
        for (int i = 0; i < 9; i++)
            send_coef(6'((i / 3) * KMAX + i % 3), rand_coef());
        for (int i = 0; i < 30; i++)
            send_pixel(rand_pixel(), 1'b0);
        settle();
        write_reg(CFG_WIDTH, 11'd5);
        for (int i = 0; i < 16; i++)
            send_pixel(rand_pixel(), i == 15);
    endtask

    // the last frame of each setting is closed so a new width starts at row zero
    task automatic test_random_frames();
        int          start;
        int unsigned w;
        int unsigned w_eff;
        int          n;
        int          frames;
        logic        close;
        start = beats_sent;
        while (beats_sent - start < 1350)
        begin
            settle();
            case ($urandom_range(0, 9))
                0: w = 0;
                1: w = $urandom_range(WMAX, 2047);
                2: w = 1;
                default: w = $urandom_range(2, 14);
            endcase
            w_eff = (w == 0) ? 1 : ((w > WMAX) ? WMAX : w);
            configure(w, $urandom_range(0, 7), $urandom_range(0, 1));
            for (int i = 0; i < NCOEF; i++)
                if ($urandom_range(0, 2) == 0)
                    send_coef(6'(i), rand_coef());
            if ($urandom_range(0, 1) == 0)
                send_coef(6'($urandom_range(NCOEF, 63)), rand_coef());
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++)
            begin
                if (w_eff > 64)
                    n = $urandom_range(20, 60);
                else
                begin
                    n = w_eff * $urandom_range(1, 9);
                    if ($urandom_range(0, 4) == 0)
                        n = $urandom_range(1, n);
                end
                close = (f == frames - 1) || ($urandom_range(0, 4) != 0);
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_coef(6'($urandom), rand_coef());
                    send_pixel(rand_pixel(), close && i == n - 1);
                end
            end
        end
    endtask

    initial
    begin : result_sink
        int stall;
        res_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_gap(rx_run);
            @(negedge clk);
            if (stall > 0)
            begin
                res_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
            check_filtered();
        end
    end

    initial
    begin
        #10_000_000;
        $display("[image_kernel_convolution_top] ERROR");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        item_valid   = 1'b0;
        op           = OP_PIXEL;
        pixel        = '0;
        end_of_frame = 1'b0;
        coef_index   = '0;
        coef_value   = '0;
        bad_pixels   = 0;
        beats_sent   = 0;
        tx_run       = 0;
        rx_run       = 0;
        row_cnt      = 0;
        col_cnt      = 0;
        width_reg    = WIDTH_RESET;
        kernel_reg   = KERNEL_RESET;
        mode_reg     = 0;
        for (int k = 0; k < KMAX - 1; k++)
            for (int c = 0; c < WMAX; c++)
                line_mem[k][c] = '0;
        for (int k = 0; k < KMAX; k++)
            for (int l = 0; l < KMAX; l++)
                win[k][l] = '0;
        for (int i = 0; i < NCOEF; i++)
            coef_tab[i] = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_coef_extremes();
        test_odd_settings();
        test_width_shrink();
        test_random_frames();

        settle();
        repeat (20) @(posedge clk);
        if (conv_results.size() != 0)
            $display("%0d results never arrived", conv_results.size());
        if (bad_pixels == 0 && conv_results.size() == 0)
            $display("[image_kernel_convolution_top] OK");
        else
            $display("[image_kernel_convolution_top] ERROR");
        $finish;
    end

endmodule
